/* rtl/obo_pkg.sv */
// shared types and constants for the oriented box overlap block
// no dependencies; used by obo_dot, obo_ivl and oriented_box_overlap_sat
package obo_pkg;

    localparam int unsigned HEAD_W    = 16;  // heading cosine/sine width, q1.14
    localparam int unsigned AXIS_W    = 17;  // axis component, room for a negated sine
    localparam int unsigned SLOT_W    = 3;   // corner slot address: box and corner index
    localparam int unsigned SLOTS     = 8;
    localparam int unsigned STEP_W    = 5;   // axis, box and corner of one projection

    // travels with each projection down the pipe
    typedef struct packed {
        logic valid;
        logic box;          // which box the projected corner belongs to
        logic first;        // first corner of the box on this axis
        logic last_corner;  // fourth corner of the box on this axis
        logic first_axis;
        logic final_axis;
    } t_tag;

endpackage

/* rtl/oriented_box_overlap_sat.sv */
// top level of the oriented rectangle overlap test by separating axes
// depends on obo_pkg, obo_dot (projection unit) and obo_ivl (interval tracker)
//
// usage
//   a corner transfer happens at a rising edge with start high and busy low.
//   i_box_select picks the box, i_corner_x/i_corner_y give the corner, and
//   i_dir_cos/i_dir_sin replace that box's heading. each box keeps up to four
//   corners per round; further corners for a full box are dropped along with
//   their heading.
//   a transfer without i_last leaves busy low.
//   a transfer with i_last stores its corner, then the sequencer walks 32
//   projections (4 axes x 2 boxes x 4 corners) through one shared multiplier
//   pair, one per cycle, behind a registered corner memory read.
//   o_valid pulses for one cycle with o_collide; busy rises at the edge that
//   took the last transfer and stays high through the o_valid cycle, so the
//   next transfer is taken only after the result has come out.
//   a round walks the 32 projections through the shared multiplier pair and
//   the four-stage pipe (memory read, products, sum, min/max).
//   the receiver cannot stall: the result is on the ports for that one cycle.
//   reset clears the corner counts and the sequencer; stored corners and
//   headings are undefined until written.
module oriented_box_overlap_sat #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_box_select,
    input  logic signed [COORD_BITS-1:0]            i_corner_x,
    input  logic signed [COORD_BITS-1:0]            i_corner_y,
    input  logic signed [obo_pkg::HEAD_W-1:0]       i_dir_cos,
    input  logic signed [obo_pkg::HEAD_W-1:0]       i_dir_sin,
    input  logic                                    i_last,
    output logic                                    o_valid,
    output logic                                    o_collide
);

    localparam int unsigned DOT_W = COORD_BITS + obo_pkg::AXIS_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                                r_state;
    logic [2:0]                            r_cnt [2];
    logic [obo_pkg::STEP_W-1:0]            r_idx;
    logic                                  accept;
    logic                                  store;

    // corner memory, {y, x} per slot
    logic [2*COORD_BITS-1:0]               r_mem [obo_pkg::SLOTS];
    logic [2*COORD_BITS-1:0]               r_rd;
    logic [obo_pkg::SLOT_W-1:0]            wr_addr;

    logic signed [obo_pkg::HEAD_W-1:0]     r_cos [2];
    logic signed [obo_pkg::HEAD_W-1:0]     r_sin [2];

    logic                                  hb;
    logic signed [obo_pkg::AXIS_W-1:0]     cos_ext;
    logic signed [obo_pkg::AXIS_W-1:0]     sin_ext;
    logic signed [obo_pkg::AXIS_W-1:0]     n_ax;
    logic signed [obo_pkg::AXIS_W-1:0]     n_ay;
    logic signed [obo_pkg::AXIS_W-1:0]     r_ax;
    logic signed [obo_pkg::AXIS_W-1:0]     r_ay;
    obo_pkg::t_tag                         n_tag;
    obo_pkg::t_tag                         r_tag;

    obo_pkg::t_tag                         dot_tag;
    logic signed [DOT_W-1:0]               dot;
    logic                                  ivl_valid;
    logic                                  ivl_collide;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    // a box takes corners until it holds four this round
    assign store   = accept && !r_cnt[i_box_select][2];
    assign wr_addr = {i_box_select, r_cnt[i_box_select][1:0]};

    // axis for the step being issued: heading (c, s) or its normal (-s, c)
    always_comb begin
        hb      = r_idx[4];
        cos_ext = obo_pkg::AXIS_W'(r_cos[hb]);
        sin_ext = obo_pkg::AXIS_W'(r_sin[hb]);
        n_ax    = r_idx[3] ? -sin_ext : cos_ext;
        n_ay    = r_idx[3] ? cos_ext  : sin_ext;

        n_tag.valid       = (r_state == S_RUN);
        n_tag.box         = r_idx[2];
        n_tag.first       = (r_idx[1:0] == '0);
        n_tag.last_corner = (r_idx[1:0] == '1);
        n_tag.first_axis  = (r_idx[4:3] == '0);
        n_tag.final_axis  = (r_idx[4:3] == '1);
    end

    // sequencer: idle takes corners, run issues 32 projections, drain waits for result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_idx    <= '0;
            r_tag    <= '0;
        end else begin
            r_tag <= n_tag;
            unique case (r_state)
                S_IDLE: begin
                    if (store) begin
                        r_cnt[i_box_select] <= r_cnt[i_box_select] + 3'd1;
                    end
                    if (accept && i_last) begin
                        r_cnt[0] <= '0;
                        r_cnt[1] <= '0;
                        r_idx    <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_idx <= r_idx + obo_pkg::STEP_W'(1);
                    if (r_idx == '1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (ivl_valid) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // corner and heading storage, registered corner read
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[wr_addr]      <= {i_corner_y, i_corner_x};
            r_cos[i_box_select] <= i_dir_cos;
            r_sin[i_box_select] <= i_dir_sin;
        end
        r_rd <= r_mem[r_idx[obo_pkg::SLOT_W-1:0]];
        r_ax <= n_ax;
        r_ay <= n_ay;
    end

    obo_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag),
        .i_x     (r_rd[COORD_BITS-1:0]),
        .i_y     (r_rd[2*COORD_BITS-1:COORD_BITS]),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .o_tag   (dot_tag),
        .o_dot   (dot)
    );

    obo_ivl #(
        .DOT_W (DOT_W)
    ) u_ivl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (dot_tag),
        .i_dot     (dot),
        .o_valid   (ivl_valid),
        .o_collide (ivl_collide)
    );

    assign o_valid   = ivl_valid;
    assign o_collide = ivl_collide;

    // a result only comes out while the sequencer waits for it
    a_valid_in_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_DRAIN))
        else $error("result strobe outside drain");

    // the last transfer starts a round
    a_last_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> (busy && r_idx == '0))
        else $error("last transfer did not start a round");

    // no box ever holds more than four corners
    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= 3'd4) && (r_cnt[1] <= 3'd4))
        else $error("corner count overflow");

    // counts are cleared while a round runs
    a_cnt_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt[0] == '0 && r_cnt[1] == '0))
        else $error("corner count not cleared");

endmodule

/* rtl/obo_dot.sv */
// shared projection unit: multiplier pair, register, adder, register
// depends on obo_pkg for the tag type and axis width
module obo_dot #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  obo_pkg::t_tag                                  i_tag,
    input  logic signed [COORD_BITS-1:0]                   i_x,
    input  logic signed [COORD_BITS-1:0]                   i_y,
    input  logic signed [obo_pkg::AXIS_W-1:0]              i_ax,
    input  logic signed [obo_pkg::AXIS_W-1:0]              i_ay,
    output obo_pkg::t_tag                                  o_tag,
    output logic signed [COORD_BITS+obo_pkg::AXIS_W:0]     o_dot
);

    localparam int unsigned PROD_W = COORD_BITS + obo_pkg::AXIS_W;
    localparam int unsigned DOT_W  = PROD_W + 1;

    obo_pkg::t_tag            r_tag_p;
    obo_pkg::t_tag            r_tag_s;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic signed [PROD_W-1:0] n_px;
    logic signed [PROD_W-1:0] n_py;
    logic signed [DOT_W-1:0]  r_dot;
    logic signed [DOT_W-1:0]  n_dot;

    always_comb begin
        n_px  = PROD_W'(i_x) * PROD_W'(i_ax);
        n_py  = PROD_W'(i_y) * PROD_W'(i_ay);
        n_dot = DOT_W'(r_px) + DOT_W'(r_py);
    end

    always_ff @(posedge i_clk) begin
        r_px  <= n_px;
        r_py  <= n_py;
        r_dot <= n_dot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_p <= '0;
            r_tag_s <= '0;
        end else begin
            r_tag_p <= i_tag;
            r_tag_s <= r_tag_p;
        end
    end

    assign o_tag = r_tag_s;
    assign o_dot = r_dot;

endmodule

/* rtl/obo_ivl.sv */
// projection interval tracker: per-box min/max, overlap test per axis
// depends on obo_pkg for the tag type
module obo_ivl #(
    parameter int unsigned DOT_W = 42
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  obo_pkg::t_tag           i_tag,
    input  logic signed [DOT_W-1:0] i_dot,
    output logic                    o_valid,
    output logic                    o_collide
);

    logic signed [DOT_W-1:0] r_lo;
    logic signed [DOT_W-1:0] r_hi;
    logic signed [DOT_W-1:0] r_lo0;
    logic signed [DOT_W-1:0] r_hi0;
    logic signed [DOT_W-1:0] n_lo;
    logic signed [DOT_W-1:0] n_hi;
    logic                    r_hit;
    logic                    r_collide;
    logic                    r_valid;
    logic                    n_overlap;
    logic                    n_hit;

    always_comb begin
        if (i_tag.first) begin
            n_lo = i_dot;
            n_hi = i_dot;
        end else begin
            n_lo = (i_dot < r_lo) ? i_dot : r_lo;
            n_hi = (i_dot > r_hi) ? i_dot : r_hi;
        end
        // touching ends count as overlap
        n_overlap = ((r_lo0 <= n_lo) && (n_lo <= r_hi0)) ||
                    ((n_lo <= r_lo0) && (r_lo0 <= n_hi));
        n_hit     = n_overlap && (i_tag.first_axis || r_hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            if (i_tag.last_corner && !i_tag.box) begin
                r_lo0 <= n_lo;
                r_hi0 <= n_hi;
            end
            if (i_tag.last_corner && i_tag.box) begin
                r_hit <= n_hit;
                if (i_tag.final_axis) begin
                    r_collide <= n_hit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tag.valid && i_tag.last_corner && i_tag.box && i_tag.final_axis;
        end
    end

    assign o_valid   = r_valid;
    assign o_collide = r_collide;

endmodule

/* verif/oriented_box_overlap_sat_test.sv */
// testbench for oriented_box_overlap_sat: separating axis overlap of two rectangles
// depends on obo_pkg and the oriented_box_overlap_sat rtl; self-checking, no files read
module oriented_box_overlap_sat_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned HEAD_W  = obo_pkg::HEAD_W;
    localparam int unsigned CORNERS_PER_BOX = 4;
    localparam int RANDOM_ITEMS = 1025;
    localparam int SETTLE_CYCLES = 60;

    // one corner transfer as it appears on the input ports
    typedef struct packed {
        logic                      box;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  cs;
        logic signed [HEAD_W-1:0]  sn;
        logic                      last;
    } t_corner;

    // directed stimulus row: typed marks an expected collide read straight off the geometry
    typedef struct packed {
        t_corner item;
        logic    typed;
        logic    want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_box_select = 1'b0;
    logic signed [COORD_W-1:0] i_corner_x = '0;
    logic signed [COORD_W-1:0] i_corner_y = '0;
    logic signed [HEAD_W-1:0]  i_dir_cos = '0;
    logic signed [HEAD_W-1:0]  i_dir_sin = '0;
    logic                      i_last = 1'b0;
    logic                      o_valid;
    logic                      o_collide;

    oriented_box_overlap_sat #(
        .COORD_BITS(COORD_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_box_select(i_box_select),
        .i_corner_x(i_corner_x),
        .i_corner_y(i_corner_y),
        .i_dir_cos(i_dir_cos),
        .i_dir_sin(i_dir_sin),
        .i_last(i_last),
        .o_valid(o_valid),
        .o_collide(o_collide)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mirror of the block state: eight corner slots (box * 4 + index), two headings,
    // and how many corners each box has taken in the current round
    longint      corner_x_mem [8];
    longint      corner_y_mem [8];
    longint      head_cos [2];
    longint      head_sin [2];
    int unsigned corners_held [2];

    bit      collide_expected [$];   // outstanding collide flags, oldest first
    int      mismatch_count = 0;
    t_corner box0_corners [$];
    t_corner box1_corners [$];
    t_corner round_items [$];

    // project both boxes on one axis and test the two intervals; touching ends overlap.
    // a zero axis maps everything to 0, so it always overlaps
    function automatic bit axis_overlaps(longint ax, longint ay);
        longint lo [2];
        longint hi [2];
        longint d;
        for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < CORNERS_PER_BOX; k++) begin
                d = corner_x_mem[b * 4 + k] * ax + corner_y_mem[b * 4 + k] * ay;
                if (k == 0 || d < lo[b]) lo[b] = d;
                if (k == 0 || d > hi[b]) hi[b] = d;
            end
        end
        return (lo[0] <= lo[1] && lo[1] <= hi[0]) || (lo[1] <= lo[0] && lo[0] <= hi[1]);
    endfunction

    // update the mirrored state with one accepted corner; on a last transfer
    // run the four-axis test and start a new round
    task automatic absorb_corner(input t_corner it, output bit fires, output bit hit);
        int unsigned b;
        int unsigned slot;
        longint      c;
        longint      s;
        b = 32'(it.box);
        // a full box drops the corner and its heading alike
        if (corners_held[b] < CORNERS_PER_BOX) begin
            slot = b * 4 + corners_held[b];
            corner_x_mem[slot] = longint'(signed'(it.x));
            corner_y_mem[slot] = longint'(signed'(it.y));
            head_cos[b] = longint'(signed'(it.cs));
            head_sin[b] = longint'(signed'(it.sn));
            corners_held[b]++;
        end
        fires = it.last;
        hit = 1'b1;
        if (it.last) begin
            // axes: heading (c, s) then its normal (-s, c), first box then second
            for (int a = 0; a < 4; a++) begin
                c = head_cos[a / 2];
                s = head_sin[a / 2];
                if (a % 2 == 0) begin
                    if (!axis_overlaps(c, s)) hit = 1'b0;
                end else begin
                    if (!axis_overlaps(-s, c)) hit = 1'b0;
                end
            end
            corners_held[0] = 0;
            corners_held[1] = 0;
        end
    endtask

    // present one corner and hold it until the block takes it
    task automatic send_corner(input t_corner it, input bit typed, input bit want);
        bit fires;
        bit hit;
        start <= 1'b1;
        i_box_select <= it.box;
        i_corner_x <= it.x;
        i_corner_y <= it.y;
        i_dir_cos <= it.cs;
        i_dir_sin <= it.sn;
        i_last <= it.last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        absorb_corner(it, fires, hit);
        if (fires) collide_expected.push_back(typed ? want : hit);
    endtask

    // sender idles; the payload ports carry junk the block must ignore
    task automatic sender_pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            i_box_select <= 1'($urandom_range(0, 1));
            i_corner_x <= COORD_W'($urandom);
            i_corner_y <= COORD_W'($urandom);
            i_dir_cos <= HEAD_W'($urandom);
            i_dir_sin <= HEAD_W'($urandom);
            i_last <= 1'($urandom_range(0, 1));
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending until every outstanding collide flag has come back
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (collide_expected.size() != 0) @(posedge i_clk);
    endtask

    // mostly no gap; long gaps land the next start anywhere in the busy window
    function automatic int pick_gap(bit quiet);
        if (quiet || $urandom_range(0, 99) >= 25) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(5, 45);
        return $urandom_range(1, 4);
    endfunction

    // heading: mostly near-unit vectors at common angles, some arbitrary, a few zero
    function automatic void pick_heading(output int c, output int s);
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            c = 0;
            s = 0;
        end else if (r < 20) begin
            c = int'($urandom_range(0, 32768)) - 16384;
            s = int'($urandom_range(0, 32768)) - 16384;
        end else begin
            case ($urandom_range(0, 4))
                0: begin c = 16384; s = 0; end
                1: begin c = 11585; s = 11585; end
                2: begin c = 14189; s = 8192; end
                3: begin c = 15137; s = 6270; end
                default: begin c = 16069; s = 3196; end
            endcase
            if ($urandom_range(0, 1)) begin
                t = c;
                c = s;
                s = t;
            end
            if ($urandom_range(0, 1)) c = -c;
            if ($urandom_range(0, 1)) s = -s;
        end
    endfunction

    function automatic t_corner raw_corner(bit b);
        t_corner it;
        int      c;
        int      s;
        pick_heading(c, s);
        it.box = b;
        it.x = COORD_W'($urandom);
        it.y = COORD_W'($urandom);
        it.cs = HEAD_W'(c);
        it.sn = HEAD_W'(s);
        it.last = 1'b0;
        return it;
    endfunction

    // a real oriented rectangle: half extents rotated by the heading around a center
    task automatic add_rect(input bit b, input int cx, input int cy);
        t_corner it;
        int      c;
        int      s;
        int      hw;
        int      hh;
        int      dx;
        int      dy;
        pick_heading(c, s);
        hw = $urandom_range(16, 4096);
        hh = $urandom_range(16, 4096);
        for (int k = 0; k < CORNERS_PER_BOX; k++) begin
            dx = (k == 1 || k == 2) ? hw : -hw;
            dy = (k >= 2) ? hh : -hh;
            it.box = b;
            it.x = COORD_W'(cx + ((dx * c - dy * s) >>> 14));
            it.y = COORD_W'(cy + ((dx * s + dy * c) >>> 14));
            it.cs = HEAD_W'(c);
            it.sn = HEAD_W'(s);
            it.last = 1'b0;
            if (b) box1_corners.push_back(it);
            else box0_corners.push_back(it);
        end
    endtask

    // one round: well-formed rectangles most of the time, raw corners, or a broken
    // sequence with short boxes and surplus corners; the two boxes are interleaved
    task automatic build_round();
        int      kind;
        int      cx;
        int      cy;
        t_corner it;
        kind = $urandom_range(0, 99);
        round_items.delete();
        box0_corners.delete();
        box1_corners.delete();
        if (kind < 60) begin
            cx = int'($urandom_range(0, 2097152)) - 1048576;
            cy = int'($urandom_range(0, 2097152)) - 1048576;
            add_rect(1'b0, cx, cy);
            add_rect(1'b1, cx + int'($urandom_range(0, 16384)) - 8192,
                     cy + int'($urandom_range(0, 16384)) - 8192);
        end else if (kind < 80) begin
            for (int k = 0; k < CORNERS_PER_BOX; k++) begin
                box0_corners.push_back(raw_corner(1'b0));
                box1_corners.push_back(raw_corner(1'b1));
            end
        end else begin
            repeat ($urandom_range(1, 10)) begin
                it = raw_corner(1'($urandom_range(0, 1)));
                if (it.box) box1_corners.push_back(it);
                else box0_corners.push_back(it);
            end
        end
        while (box0_corners.size() != 0 || box1_corners.size() != 0) begin
            if (box0_corners.size() == 0) round_items.push_back(box1_corners.pop_front());
            else if (box1_corners.size() == 0) round_items.push_back(box0_corners.pop_front());
            else if ($urandom_range(0, 1)) round_items.push_back(box1_corners.pop_front());
            else round_items.push_back(box0_corners.pop_front());
        end
        round_items[round_items.size() - 1].last = 1'b1;
    endtask

    function automatic t_stim_row row(bit b, int x, int y, int c, int s, bit lst,
                                      bit typed, bit want);
        t_stim_row r;
        r.item.box = b;
        r.item.x = COORD_W'(x);
        r.item.y = COORD_W'(y);
        r.item.cs = HEAD_W'(c);
        r.item.sn = HEAD_W'(s);
        r.item.last = lst;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    // every result strobe is taken at the edge that ends its cycle
    always @(posedge i_clk) begin : collide_check
        bit want;
        if (i_rst_n && o_valid) begin
            if (collide_expected.size() == 0) begin
                $display("%0t: collide expected none, got %0b", $time, o_collide);
                mismatch_count++;
            end else begin
                want = collide_expected.pop_front();
                if (o_collide !== want) begin
                    $display("%0t: collide expected %0b, got %0b", $time, want, o_collide);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row directed_rows [$];
        int        items_sent;
        int        round_no;

        for (int k = 0; k < 8; k++) begin
            corner_x_mem[k] = 0;
            corner_y_mem[k] = 0;
        end
        for (int b = 0; b < 2; b++) begin
            head_cos[b] = 0;
            head_sin[b] = 0;
            corners_held[b] = 0;
        end

        // axis-aligned unit squares side by side: they touch on x, which counts as overlap.
        // this round also fills every slot and heading before any test reads them
        directed_rows.push_back(row(0, 0, 0, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(0, 256, 0, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(0, 256, 256, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(0, 0, 256, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(1, 256, 0, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(1, 512, 0, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(1, 512, 256, 16384, 0, 0, 0, 0));
        directed_rows.push_back(row(1, 256, 256, 16384, 0, 1, 1, 1));
        // coordinate extremes: a full-range box around a tiny one, extreme headings;
        // containment overlaps on any axis
        directed_rows.push_back(row(0, 8388607, 8388607, 16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(1, -1, -1, -16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(0, -8388608, 8388607, 16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(1, 1, -1, -16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(0, -8388608, -8388608, 16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(1, 1, 1, -16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(0, 8388607, -8388608, 16384, -16384, 0, 0, 0));
        directed_rows.push_back(row(1, -1, 1, -16384, -16384, 1, 1, 1));
        // short second box keeps three old corners; the first box gets a surplus
        // corner that arrives with last and is dropped while the test still runs
        directed_rows.push_back(row(1, 1000, 1000, 0, 16384, 0, 0, 0));
        directed_rows.push_back(row(0, -300, -300, 11585, -11585, 0, 0, 0));
        directed_rows.push_back(row(0, -200, -300, 11585, -11585, 0, 0, 0));
        directed_rows.push_back(row(0, -200, -200, 11585, -11585, 0, 0, 0));
        directed_rows.push_back(row(0, -300, -200, 11585, -11585, 0, 0, 0));
        directed_rows.push_back(row(0, 5000, 5000, -16384, 0, 1, 0, 0));
        // zero headings on both boxes: every axis collapses to a point, so they collide
        directed_rows.push_back(row(0, -8388608, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(1, 8388607, 8388607, 0, 0, 1, 1, 1));
        // a round of a single last transfer
        directed_rows.push_back(row(1, 0, 0, 16384, 0, 1, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            send_corner(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
            sender_pause(pick_gap(1'b0));
        end
        hold_until_drained();

        // random rounds; rounds 30 to 55 run back to back with no sender gaps
        items_sent = 0;
        round_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (round_no % 50 == 10) hold_until_drained();
            build_round();
            foreach (round_items[n]) begin
                send_corner(round_items[n], 1'b0, 1'b0);
                sender_pause(pick_gap(round_no >= 30 && round_no <= 55));
            end
            items_sent += round_items.size();
            round_no++;
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // about ten times the slowest legal run
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
